>>> src/rarest_first_piece_picker_macros.svh
// Assertion macros shared by the picker's checks.
`ifndef RAREST_FIRST_PIECE_PICKER_MACROS_SVH
`define RAREST_FIRST_PIECE_PICKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RFPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RFPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/rfpp_pkg.sv
// Package with the picker's codes, state type and default sizes.
package rfpp_pkg;
    localparam int unsigned DEF_MAX_PIECES = 1024;
    localparam int unsigned DEF_COUNT_BITS = 16;
    localparam int unsigned CFG_W = 11;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    typedef enum logic [1:0] {
        ST_MISSING   = 2'd0,
        ST_REQUESTED = 2'd1,
        ST_COMPLETE  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        OP_MARK_MISSING   = 3'd0,
        OP_MARK_REQUESTED = 3'd1,
        OP_MARK_COMPLETE  = 3'd2,
        OP_SET_COUNT      = 3'd3,
        OP_RESET_COUNTS   = 3'd4,
        OP_SET_PEER       = 3'd5,
        OP_CLEAR_PEERS    = 3'd6,
        OP_PICK           = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DIV,
        S_LOCATE,
        S_FIN
    } t_state;
endpackage

>>> src/rarest_first_piece_picker.sv
// Rarest-first piece picker: per-piece state in one memory, scanned per word.
//
//  channel   | valid     | stall     | payload
//  ----------+-----------+-----------+-------------------------------------------
//  input     | i_valid   | o_stall   | i_operation, i_piece_index, i_value,
//            |           |           | i_random_value
//  output    | o_valid   | i_stall   | o_picked_valid, o_picked_index,
//            |           |           | o_all_complete, o_complete_count
//  config    | i_cfg_wr_en (write)   | i_cfg_wr_data (pieces_in_use)
//
// Every word costs one full read-modify-write pass over the MAX_PIECES entries
// of the piece memory, which also recounts complete pieces. A pick that finds a
// candidate adds a bit-serial remainder of i_random_value by the tie count and a
// second read pass that stops at the chosen piece. After reset a clearing pass
// writes every entry with o_stall high. A finished result waits in the output
// register while i_stall is high; the next word is taken as soon as the block is
// idle and leaves its own result stage only once that register is free.
module rarest_first_piece_picker
    import rfpp_pkg::*;
#(
    parameter int unsigned MAX_PIECES = DEF_MAX_PIECES,
    parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [9:0]  i_piece_index,
    input  logic [15:0] i_value,
    input  logic [31:0] i_random_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_picked_valid,
    output logic [9:0]  o_picked_index,
    output logic        o_all_complete,
    output logic [10:0] o_complete_count
);
    `include "rarest_first_piece_picker_macros.svh"

    localparam int unsigned IDX_W = $clog2(MAX_PIECES);
    localparam int unsigned NW = IDX_W + 1;
    localparam int unsigned EW = 3 + COUNT_BITS;
    localparam longint unsigned CMAX = (64'd1 << COUNT_BITS) - 64'd1;
    localparam logic [NW-1:0] LAST = NW'(MAX_PIECES - 1);

    // Entry layout: {status[1:0], peer, count}.
    logic [EW-1:0] r_mem [MAX_PIECES];
    logic [EW-1:0] r_q;

    t_state r_state, n_state;
    logic [10:0]   r_cfg;
    t_op           r_op;
    logic [9:0]    r_idx;
    logic [15:0]   r_val;
    logic [31:0]   r_rnd;
    logic [NW-1:0] r_nact;
    logic          r_inr;
    logic [NW-1:0] r_addr;
    logic          r_dvld;
    logic [NW-1:0] r_didx;
    logic [NW-1:0] r_ccnt;
    logic          r_have;
    logic [COUNT_BITS-1:0] r_best;
    logic [NW-1:0] r_ties;
    logic [NW:0]   r_rem;
    logic [4:0]    r_dcnt;
    logic [NW-1:0] r_seen;
    logic          r_found;
    logic [NW-1:0] r_pidx;
    logic          r_ovld;
    logic          r_opv;
    logic [9:0]    r_opidx;
    logic          r_oall;
    logic [10:0]   r_occ;

    // Combinational signals.
    logic          accept;
    logic [NW-1:0] n_act;
    logic          issue;
    logic          mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    t_status       q_st, e_st;
    logic          q_peer, e_peer;
    logic [COUNT_BITS-1:0] q_cnt, e_cnt, sat_val;
    logic          d_act, d_hit, d_cand;
    logic          scan_last, loc_match, out_free;
    logic [NW:0]   rem_sh;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_ovld || !i_stall;
    assign n_act    = (32'(r_cfg) > 32'(MAX_PIECES)) ? NW'(MAX_PIECES) : NW'(r_cfg);
    assign sat_val  = (64'(r_val) > CMAX) ? COUNT_BITS'(CMAX) : COUNT_BITS'(r_val);

    assign q_st   = t_status'(r_q[EW-1 -: 2]);
    assign q_peer = r_q[COUNT_BITS];
    assign q_cnt  = r_q[COUNT_BITS-1:0];
    assign d_act  = r_didx < r_nact;
    assign d_hit  = r_inr && (32'(r_didx) == 32'(r_idx));

    // Apply the word's operation to the entry coming out of the memory.
    always_comb begin
        e_st   = q_st;
        e_peer = q_peer;
        e_cnt  = q_cnt;
        if (r_op == OP_RESET_COUNTS) begin
            e_cnt = COUNT_BITS'(1);
        end
        if (r_op == OP_CLEAR_PEERS) begin
            e_peer = 1'b0;
        end
        if (d_hit) begin
            case (r_op)
                OP_MARK_MISSING:   e_st = ST_MISSING;
                OP_MARK_REQUESTED: e_st = ST_REQUESTED;
                OP_MARK_COMPLETE:  e_st = ST_COMPLETE;
                OP_SET_COUNT:      e_cnt = sat_val;
                OP_SET_PEER:       e_peer = r_val[0];
                default:           e_st = q_st;
            endcase
        end
    end

    assign d_cand    = d_act && (e_st == ST_MISSING) && e_peer;
    assign scan_last = r_dvld && (r_didx == LAST);
    assign loc_match = r_dvld && d_cand && (e_cnt == r_best)
                       && (r_seen == r_rem[NW-1:0]);
    assign rem_sh    = {r_rem[NW-1:0], r_rnd[31]};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_addr == LAST) n_state = S_IDLE;
            S_IDLE:   if (accept) n_state = S_SCAN;
            S_SCAN: begin
                // The last entry may be the first candidate, so it counts here too.
                if (scan_last) begin
                    n_state = (r_op == OP_PICK && (r_have || d_cand)) ? S_DIV : S_FIN;
                end
            end
            S_DIV:    if (r_dcnt == 5'd31) n_state = S_LOCATE;
            S_LOCATE: if (loc_match || scan_last) n_state = S_FIN;
            S_FIN:    if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Memory control.
    always_comb begin
        issue  = 1'b0;
        mem_we = 1'b0;
        mem_wa = r_didx[IDX_W-1:0];
        mem_wd = {e_st, e_peer, e_cnt};
        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_addr[IDX_W-1:0];
                mem_wd = {ST_MISSING, 1'b0, COUNT_BITS'(1)};
            end
            S_SCAN: begin
                issue  = r_addr < NW'(MAX_PIECES);
                mem_we = r_dvld;
            end
            S_LOCATE: begin
                issue  = r_addr < NW'(MAX_PIECES);
                mem_we = loc_match;
                mem_wd = {ST_REQUESTED, e_peer, e_cnt};
            end
            default: begin
                issue  = 1'b0;
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_q <= r_mem[r_addr[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cfg   <= CFG_RESET;
            r_addr  <= '0;
            r_dvld  <= 1'b0;
            r_ovld  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_cfg <= i_cfg_wr_data;
            end
            r_dvld <= issue;
            r_didx <= r_addr;
            if (issue || r_state == S_CLEAR) begin
                r_addr <= r_addr + NW'(1);
            end
            // In the result stage the register is reloaded instead of freed.
            if (r_ovld && !i_stall && r_state != S_FIN) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_addr  <= '0;
                    r_found <= 1'b0;
                    if (accept) begin
                        r_op   <= t_op'(i_operation);
                        r_idx  <= i_piece_index;
                        r_val  <= i_value;
                        r_rnd  <= i_random_value;
                        r_nact <= n_act;
                        r_inr  <= 32'(i_piece_index) < 32'(n_act);
                        r_ccnt <= '0;
                        r_have <= 1'b0;
                        r_ties <= '0;
                        r_rem  <= '0;
                        r_dcnt <= '0;
                        r_seen <= '0;
                        r_pidx <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_dvld) begin
                        if (d_act && e_st == ST_COMPLETE) begin
                            r_ccnt <= r_ccnt + NW'(1);
                        end
                        if (d_cand) begin
                            if (!r_have || e_cnt < r_best) begin
                                r_have <= 1'b1;
                                r_best <= e_cnt;
                                r_ties <= NW'(1);
                            end else if (e_cnt == r_best) begin
                                r_ties <= r_ties + NW'(1);
                            end
                        end
                    end
                    if (scan_last) begin
                        r_addr <= '0;
                    end
                end
                S_DIV: begin
                    // Restoring remainder, one dividend bit per cycle.
                    r_rnd  <= {r_rnd[30:0], 1'b0};
                    r_dcnt <= r_dcnt + 5'd1;
                    if (rem_sh >= {1'b0, r_ties}) begin
                        r_rem <= rem_sh - {1'b0, r_ties};
                    end else begin
                        r_rem <= rem_sh;
                    end
                end
                S_LOCATE: begin
                    if (loc_match) begin
                        r_found <= 1'b1;
                        r_pidx  <= r_didx;
                    end else if (r_dvld && d_cand && e_cnt == r_best) begin
                        r_seen <= r_seen + NW'(1);
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_ovld  <= 1'b1;
                        r_opv   <= r_found;
                        r_opidx <= r_found ? r_pidx[9:0] : 10'd0;
                        r_oall  <= r_ccnt == r_nact;
                        r_occ   <= 11'(r_ccnt);
                    end
                end
                default: begin
                    r_found <= r_found;
                end
            endcase
        end
    end

    assign o_stall          = r_state != S_IDLE;
    assign o_valid          = r_ovld;
    assign o_picked_valid   = r_opv;
    assign o_picked_index   = r_opidx;
    assign o_all_complete   = r_oall;
    assign o_complete_count = r_occ;

    `RFPP_ASSERT_NOW(a_no_pick_zero_idx, i_clk, i_rst_n, o_valid && !o_picked_valid, o_picked_index == 10'd0, "index set without a pick")
    `RFPP_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "block took a word but did not go busy")
    `RFPP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_valid, 32'(o_complete_count) <= 32'(MAX_PIECES), "complete count above the number of pieces")
endmodule
